### hw/rtl/iso_dt_pkg.sv
// Shared constants for the date/time text parser: character codes,
// parse-mode commands, window lengths, field widths and reset values. No dependencies.
`default_nettype none

package iso_dt_pkg;

  // parse-mode commands, sampled on the first character of a string
  localparam logic [1:0] CMD_DATE      = 2'd0;
  localparam logic [1:0] CMD_TIME      = 2'd1;
  localparam logic [1:0] CMD_DATE_TIME = 2'd2;
  localparam logic [1:0] CMD_SPARE     = 2'd3;  // behaves as CMD_DATE_TIME

  // character codes
  localparam logic [7:0] CH_T     = 8'h54;  // 'T'
  localparam logic [7:0] CH_Z     = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // numeric window lengths
  localparam logic [2:0] YEAR_LEN  = 3'd4;
  localparam logic [2:0] FIELD_LEN = 3'd2;

  // field widths
  localparam int unsigned YEAR_W = 15;
  localparam int unsigned FLD_W  = 8;
  localparam int unsigned ZONE_W = 14;
  localparam int unsigned VAL_W  = 14;

  // reset values of the stored fields
  localparam logic [YEAR_W-1:0] YEAR_RST = 15'd1970;
  localparam logic [FLD_W-1:0]  DAY_RST  = 8'd1;

endpackage

`default_nettype wire

### hw/rtl/iso_date_time_text_parser_top.sv
// Top level of the date/time text parser: input register, one-pass
// character parser and result register. Depends on iso_dt_pkg.
`default_nettype none

// Channel  Direction  Handshake                Payload
// in_      input      in_valid / in_ready      in_command, in_char_in, in_last
// out_     output     out_valid / out_ready    out_year .. out_zone_offset
//
// Flow: one character per cycle while no stall holds it; a character is held in the
//   input register, and the result of a last character is loaded from there
//   into the result register.
// The parse step is one combinational pass: at most one separator phase
//   falls through into the next window, then one multiply-by-ten accumulate.
// Reset (rst_n low, synchronous) empties both registers, returns the parser to
//   the start of a string and loads the stored fields with 1970-01-01 00:00:00
//   and zone 0.
// Stalls: only a last character waits in the input register while an untaken
//   result still occupies the result register; other characters keep flowing.

module iso_date_time_text_parser_top (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [1:0]        in_command,
  input  wire  [7:0]        in_char_in,
  input  wire               in_last,
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [14:0] out_year,
  output logic signed [7:0]  out_month,
  output logic signed [7:0]  out_day,
  output logic signed [7:0]  out_hours,
  output logic signed [7:0]  out_minutes,
  output logic signed [7:0]  out_seconds,
  output logic signed [13:0] out_zone_offset
);

  localparam int unsigned YW = iso_dt_pkg::YEAR_W;
  localparam int unsigned FW = iso_dt_pkg::FLD_W;
  localparam int unsigned ZW = iso_dt_pkg::ZONE_W;
  localparam int unsigned VW = iso_dt_pkg::VAL_W;

  typedef enum logic [4:0] {
    PH_START, PH_YEAR, PH_DSEP1, PH_MONTH, PH_DSEP2, PH_DAY, PH_TSEP,
    PH_HOUR, PH_HSEP1, PH_MIN, PH_HSEP2, PH_SEC, PH_FRACCHK, PH_FRAC,
    PH_ZSIGN, PH_ZH, PH_ZSEP, PH_ZM, PH_DONE
  } phase_t;

  // strtol-style scan stage of the current window
  typedef enum logic [1:0] {
    SC_WS, SC_SIGN, SC_DIGIT, SC_STOP
  } scan_t;

  // ---------------- input register ----------------
  logic       s1_valid_r;
  logic [1:0] s1_cmd_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       fire;
  logic       out_valid_r;
  logic       load;

  // a non-last character never needs the result register
  assign fire      = s1_valid_r && (!s1_last_r || !out_valid || out_ready);
  assign in_ready  = !s1_valid_r || fire;
  assign load      = fire && s1_last_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_cmd_r  <= in_command;
      s1_char_r <= in_char_in;
      s1_last_r <= in_last;
    end
  end

  // ---------------- parser state ----------------
  phase_t        phase_r, phase_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  scan_t         stg_r, stg_nxt;
  logic          neg_r, neg_nxt;
  logic [VW-1:0] val_r, val_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [YW-1:0] year_r, year_nxt;
  logic [FW-1:0] month_r, month_nxt, day_r, day_nxt;
  logic [FW-1:0] hours_r, hours_nxt, minutes_r, minutes_nxt, seconds_r, seconds_nxt;
  logic [ZW-1:0] zone_r, zone_nxt;
  logic          zneg_r, zneg_nxt;
  logic [FW-1:0] zhold_r, zhold_nxt;

  // character classes
  logic [7:0] c;
  logic       is_digit, is_space;
  logic [3:0] dig;

  assign c        = s1_char_r;
  assign is_digit = (c >= iso_dt_pkg::CH_ZERO) && (c <= iso_dt_pkg::CH_NINE);
  assign is_space = (c == iso_dt_pkg::CH_SPACE) ||
                    ((c >= iso_dt_pkg::CH_TAB) && (c <= iso_dt_pkg::CH_CR));
  assign dig      = c[3:0];

  // scanner outputs
  logic [2:0]    sc_cnt;
  scan_t         sc_stg;
  logic          sc_neg;
  logic [VW-1:0] sc_val;
  logic [YW-1:0] sc_mag, sc_sv;
  logic          win_end;
  logic          consumed;
  logic [ZW-1:0] zh_x, zprod, zsum;

  always_comb begin
    mode_nxt    = mode_r;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    stg_nxt     = stg_r;
    neg_nxt     = neg_r;
    val_nxt     = val_r;
    year_nxt    = year_r;
    month_nxt   = month_r;
    day_nxt     = day_r;
    hours_nxt   = hours_r;
    minutes_nxt = minutes_r;
    seconds_nxt = seconds_r;
    zone_nxt    = zone_r;
    zneg_nxt    = zneg_r;
    zhold_nxt   = zhold_r;
    consumed    = 1'b0;

    // first character: latch the mode and open the first window
    if (phase_r == PH_START) begin
      mode_nxt  = s1_cmd_r;
      phase_nxt = (s1_cmd_r == iso_dt_pkg::CMD_TIME) ? PH_HOUR : PH_YEAR;
      cnt_nxt   = 3'd0;
      stg_nxt   = SC_WS;
      neg_nxt   = 1'b0;
      val_nxt   = '0;
    end

    // separator phases; an unexpected delimiter falls through to the window, a missing 'T' ends the parse
    case (phase_nxt)
      PH_DSEP1, PH_DSEP2, PH_HSEP1, PH_HSEP2, PH_ZSEP: begin
        case (phase_nxt)
          PH_DSEP1: phase_nxt = PH_MONTH;
          PH_DSEP2: phase_nxt = PH_DAY;
          PH_HSEP1: phase_nxt = PH_MIN;
          PH_HSEP2: phase_nxt = PH_SEC;
          default:  phase_nxt = PH_ZM;
        endcase
        consumed = (phase_nxt == PH_MONTH || phase_nxt == PH_DAY) ?
                   (c == iso_dt_pkg::CH_MINUS) : (c == iso_dt_pkg::CH_COLON);
        cnt_nxt = 3'd0;
        stg_nxt = SC_WS;
        neg_nxt = 1'b0;
        val_nxt = '0;
      end
      PH_TSEP: begin
        consumed = 1'b1;
        if (c == iso_dt_pkg::CH_T) begin
          phase_nxt = PH_HOUR;
          cnt_nxt   = 3'd0;
          stg_nxt   = SC_WS;
          neg_nxt   = 1'b0;
          val_nxt   = '0;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_FRACCHK: begin
        if (c == iso_dt_pkg::CH_COMMA) begin
          phase_nxt = PH_FRAC;
          consumed  = 1'b1;
        end else begin
          phase_nxt = PH_ZSIGN;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          consumed = 1'b1;
        end else begin
          phase_nxt = PH_ZSIGN;
        end
      end
      default: ;
    endcase

    // strtol-style scan of one character
    sc_stg = stg_nxt;
    sc_neg = neg_nxt;
    sc_val = val_nxt;
    case (stg_nxt)
      SC_WS: begin
        if (is_space) begin
          sc_stg = SC_WS;
        end else if (c == iso_dt_pkg::CH_PLUS || c == iso_dt_pkg::CH_MINUS) begin
          sc_neg = (c == iso_dt_pkg::CH_MINUS);
          sc_stg = SC_SIGN;
        end else if (is_digit) begin
          sc_val = {{(VW-4){1'b0}}, dig};
          sc_stg = SC_DIGIT;
        end else begin
          sc_stg = SC_STOP;
        end
      end
      SC_SIGN: begin
        if (is_digit) begin
          sc_val = {{(VW-4){1'b0}}, dig};
          sc_stg = SC_DIGIT;
        end else begin
          sc_stg = SC_STOP;
        end
      end
      SC_DIGIT: begin
        if (is_digit) begin
          sc_val = VW'((val_nxt << 3) + (val_nxt << 1) + {{(VW-4){1'b0}}, dig});
        end else begin
          sc_stg = SC_STOP;
        end
      end
      default: ;
    endcase
    sc_cnt  = cnt_nxt + 3'd1;
    sc_mag  = {{(YW-VW){1'b0}}, sc_val};
    sc_sv   = sc_neg ? YW'(~sc_mag + 1'b1) : sc_mag;
    win_end = sc_cnt >= ((phase_nxt == PH_YEAR) ? iso_dt_pkg::YEAR_LEN
                                                : iso_dt_pkg::FIELD_LEN);

    // zone = +-(hours * 60 + minutes), 60x as 64x - 4x
    zh_x  = {{(ZW-FW){zhold_r[FW-1]}}, zhold_r};
    zprod = ZW'((zh_x << 6) - (zh_x << 2));
    zsum  = zprod + sc_sv[ZW-1:0];

    if (!consumed) begin
      case (phase_nxt)
        PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MIN, PH_SEC, PH_ZH, PH_ZM: begin
          cnt_nxt = sc_cnt;
          stg_nxt = sc_stg;
          neg_nxt = sc_neg;
          val_nxt = sc_val;
          case (phase_nxt)
            PH_YEAR: begin
              year_nxt = sc_sv;
              if (win_end) phase_nxt = PH_DSEP1;
            end
            PH_MONTH: begin
              month_nxt = sc_sv[FW-1:0];
              if (win_end) phase_nxt = PH_DSEP2;
            end
            PH_DAY: begin
              day_nxt = sc_sv[FW-1:0];
              if (win_end) begin
                phase_nxt = (mode_nxt == iso_dt_pkg::CMD_DATE) ? PH_DONE : PH_TSEP;
              end
            end
            PH_HOUR: begin
              hours_nxt = sc_sv[FW-1:0];
              if (win_end) phase_nxt = PH_HSEP1;
            end
            PH_MIN: begin
              minutes_nxt = sc_sv[FW-1:0];
              if (win_end) phase_nxt = PH_HSEP2;
            end
            PH_SEC: begin
              seconds_nxt = sc_sv[FW-1:0];
              if (win_end) phase_nxt = PH_FRACCHK;
            end
            PH_ZH: begin
              zhold_nxt = sc_sv[FW-1:0];
              if (win_end) phase_nxt = PH_ZSEP;
            end
            default: begin
              zone_nxt = zneg_r ? ZW'(~zsum + 1'b1) : zsum;
              if (win_end) phase_nxt = PH_DONE;
            end
          endcase
        end
        PH_ZSIGN: begin
          if (c == iso_dt_pkg::CH_Z) begin
            phase_nxt = PH_DONE;
          end else begin
            zneg_nxt  = (c == iso_dt_pkg::CH_MINUS);
            phase_nxt = PH_ZH;
            cnt_nxt   = 3'd0;
            stg_nxt   = SC_WS;
            neg_nxt   = 1'b0;
            val_nxt   = '0;
          end
        end
        default: ;
      endcase
    end

    // end of string: back to the start, stored fields kept
    if (s1_last_r) begin
      phase_nxt = PH_START;
      cnt_nxt   = 3'd0;
      stg_nxt   = SC_WS;
      neg_nxt   = 1'b0;
      val_nxt   = '0;
    end
  end

  // parser state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      cnt_r       <= 3'd0;
      stg_r       <= SC_WS;
      neg_r       <= 1'b0;
      val_r       <= '0;
      mode_r      <= iso_dt_pkg::CMD_DATE;
      year_r      <= iso_dt_pkg::YEAR_RST;
      month_r     <= iso_dt_pkg::DAY_RST;
      day_r       <= iso_dt_pkg::DAY_RST;
      hours_r     <= '0;
      minutes_r   <= '0;
      seconds_r   <= '0;
      zone_r      <= '0;
      zneg_r      <= 1'b0;
      zhold_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r   <= phase_nxt;
        cnt_r     <= cnt_nxt;
        stg_r     <= stg_nxt;
        neg_r     <= neg_nxt;
        val_r     <= val_nxt;
        mode_r    <= mode_nxt;
        year_r    <= year_nxt;
        month_r   <= month_nxt;
        day_r     <= day_nxt;
        hours_r   <= hours_nxt;
        minutes_r <= minutes_nxt;
        seconds_r <= seconds_nxt;
        zone_r    <= zone_nxt;
        zneg_r    <= zneg_nxt;
        zhold_r   <= zhold_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (load) begin
      out_year        <= year_nxt;
      out_month       <= month_nxt;
      out_day         <= day_nxt;
      out_hours       <= hours_nxt;
      out_minutes     <= minutes_nxt;
      out_seconds     <= seconds_nxt;
      out_zone_offset <= zone_nxt;
    end
  end

  // ---------------- assertions ----------------
  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_START) |-> (cnt_r == 3'd0 && stg_r == SC_WS))
    else $error("window state not cleared at string start");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= iso_dt_pkg::YEAR_LEN)
    else $error("window count past the longest window");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !load)
    else $error("result overwritten before transfer");

  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_valid_r && phase_r == PH_START))
    else $error("last character did not give a result and restart");

endmodule

`default_nettype wire
